>>> rtl/fba_pkg.sv
`default_nettype none

package fba_pkg;

  localparam int IDX_W   = 4;
  localparam int FSIZE_W = 16;
  localparam int FRAG_W  = 24;
  localparam int COUNT_W = 16;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_LOAD   = 2'd1;
  localparam logic [1:0] MODE_ALLOC  = 2'd2;
  localparam logic [1:0] MODE_REPORT = 2'd3;

  localparam logic [FRAG_W-1:0]  FRAG_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [IDX_W-1:0]   block_index;
    logic [FSIZE_W-1:0] block_size;
    logic [FSIZE_W-1:0] request_size;
  } fba_in_t;

  typedef struct packed {
    logic               granted;
    logic [IDX_W-1:0]   chosen_block;
    logic [FSIZE_W-1:0] left_in_block;
    logic [FRAG_W-1:0]  internal_frag;
    logic [FRAG_W-1:0]  external_frag;
  } fba_out_t;

  typedef struct packed {
    logic clear;
    logic alloc;
    logic report;
    logic policy;
    logic eval;
    logic slot_ok;
  } fba_ctl_t;

endpackage

`default_nettype wire

>>> rtl/fba_table.sv
`default_nettype none

module fba_table #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16,
  parameter int AW         = 4
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [SIZE_BITS-1:0]        wr_rem,
  input  wire logic [fba_pkg::COUNT_W-1:0] wr_cnt,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [SIZE_BITS-1:0]        rd_rem,
  output logic      [fba_pkg::COUNT_W-1:0] rd_cnt
);
  import fba_pkg::*;

  logic [COUNT_W+SIZE_BITS-1:0] mem [NUM_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_cnt, wr_rem};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_cnt, rd_rem} <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/fba_scan.sv
`default_nettype none

module fba_scan #(
  parameter int SIZE_BITS = 16,
  parameter int AW        = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire fba_pkg::fba_ctl_t           ctl,
  input  wire logic [AW-1:0]               rd_idx,
  input  wire logic [SIZE_BITS-1:0]        rd_rem,
  input  wire logic [fba_pkg::COUNT_W-1:0] rd_cnt,
  input  wire logic [SIZE_BITS-1:0]        req,
  output logic                             found,
  output logic      [AW-1:0]               pick_idx,
  output logic      [SIZE_BITS-1:0]        pick_rem,
  output logic      [fba_pkg::COUNT_W-1:0] pick_cnt,
  output logic      [fba_pkg::FRAG_W-1:0]  intf,
  output logic      [fba_pkg::FRAG_W-1:0]  extf
);
  import fba_pkg::*;

  localparam int PW = (COUNT_W + SIZE_BITS > FRAG_W) ? COUNT_W + SIZE_BITS : FRAG_W;
  localparam int EW = (SIZE_BITS > FRAG_W) ? SIZE_BITS : FRAG_W;

  logic                       found_r, found_nxt;
  logic [AW-1:0]              pick_idx_r;
  logic [SIZE_BITS-1:0]       pick_rem_r;
  logic [COUNT_W-1:0]         pick_cnt_r;
  logic                       take;
  logic                       fits;
  logic                       better;

  logic [COUNT_W+SIZE_BITS-1:0] prod_w;
  logic [PW-1:0]                prod_nxt;
  logic [PW-1:0]                prod_r;
  logic [SIZE_BITS-1:0]         rem2_r;
  logic                         s2_vld_r, s2_vld_nxt;
  logic [EW-1:0]                rem2_ext;
  logic [FRAG_W-1:0]            prod_clamp;
  logic [FRAG_W-1:0]            rem_clamp;
  logic [FRAG_W:0]              isum;
  logic [FRAG_W:0]              esum;
  logic [FRAG_W-1:0]            intf_r, intf_nxt;
  logic [FRAG_W-1:0]            extf_r, extf_nxt;

  assign fits   = (rd_rem >= req);
  assign better = !found_r || (ctl.policy && (rd_rem < pick_rem_r));
  assign take   = ctl.eval && ctl.alloc && ctl.slot_ok && fits && better;

  always_comb begin
    found_nxt = found_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
    end
  end

  assign prod_w     = rd_cnt * rd_rem;
  assign prod_nxt   = PW'(prod_w);
  assign s2_vld_nxt = ctl.eval && ctl.report && ctl.slot_ok && !ctl.clear;

  assign rem2_ext   = EW'(rem2_r);
  assign prod_clamp = (prod_r > PW'(FRAG_MAX)) ? FRAG_MAX : prod_r[FRAG_W-1:0];
  assign rem_clamp  = (rem2_ext > EW'(FRAG_MAX)) ? FRAG_MAX : rem2_ext[FRAG_W-1:0];
  assign isum       = {1'b0, intf_r} + {1'b0, prod_clamp};
  assign esum       = {1'b0, extf_r} + {1'b0, rem_clamp};

  always_comb begin
    intf_nxt = intf_r;
    extf_nxt = extf_r;
    if (ctl.clear) begin
      intf_nxt = '0;
      extf_nxt = '0;
    end else if (s2_vld_r) begin
      intf_nxt = isum[FRAG_W] ? FRAG_MAX : isum[FRAG_W-1:0];
      extf_nxt = esum[FRAG_W] ? FRAG_MAX : esum[FRAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r  <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      found_r  <= found_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx_r <= rd_idx;
      pick_rem_r <= rd_rem;
      pick_cnt_r <= rd_cnt;
    end
    prod_r <= prod_nxt;
    rem2_r <= rd_rem;
    intf_r <= intf_nxt;
    extf_r <= extf_nxt;
  end

  assign found    = found_r;
  assign pick_idx = pick_idx_r;
  assign pick_rem = pick_rem_r;
  assign pick_cnt = pick_cnt_r;
  assign intf     = intf_r;
  assign extf     = extf_r;

endmodule

`default_nettype wire

>>> rtl/fit_block_allocator.sv
`default_nettype none

// Each item takes one result, delivered on out_valid for exactly one cycle; the receiver
// cannot stall it. A clear or a load finishes at once and its result follows in the cycle after
// start. An allocate or a report walks the block table through its single read port, one entry
// per cycle, and busy holds through the scan, drain and finish states; its result appears
// in the cycle busy falls. The next start may be given in that same cycle. The policy
// register is written through the cfg_ channel while the block is not busy.
module fit_block_allocator #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire fba_pkg::fba_in_t  in_data,
  output logic                   out_valid,
  output fba_pkg::fba_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);
  import fba_pkg::*;

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = AW + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        scan_cnt_r, scan_cnt_nxt;
  logic                 drain_r, drain_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]        s1_idx_r;
  logic [NUM_BLOCKS-1:0] slot_valid_r, slot_valid_nxt;
  logic                 policy_r;
  fba_in_t              item_r;
  logic                 out_valid_r, out_valid_nxt;
  fba_out_t             out_data_r, out_data_nxt;

  logic                 accept;
  logic                 ld_ok;
  logic [31:0]          ld_idx_w;
  logic [31:0]          bsize_w;
  logic [31:0]          req_w;
  logic [SIZE_BITS-1:0] req_m;
  logic [31:0]          left_w;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [SIZE_BITS-1:0] wr_rem;
  logic [COUNT_W-1:0]   wr_cnt;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [SIZE_BITS-1:0] rd_rem;
  logic [COUNT_W-1:0]   rd_cnt;

  fba_ctl_t             ctl;
  logic                 found;
  logic [AW-1:0]        pick_idx;
  logic [SIZE_BITS-1:0] pick_rem;
  logic [COUNT_W-1:0]   pick_cnt;
  logic [SIZE_BITS-1:0] new_rem;
  logic [31:0]          pick_idx_w;
  logic [FRAG_W-1:0]    intf;
  logic [FRAG_W-1:0]    extf;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign ld_idx_w = 32'(in_data.block_index);
  assign bsize_w  = 32'(in_data.block_size);
  assign ld_ok    = (ld_idx_w < 32'(NUM_BLOCKS));
  assign req_w    = 32'(item_r.request_size);
  assign req_m    = req_w[SIZE_BITS-1:0];
  assign new_rem  = pick_rem - req_m;
  assign left_w   = 32'(new_rem);
  assign pick_idx_w = 32'(pick_idx);

  assign rd_en   = (state_r == ST_SCAN);
  assign rd_addr = scan_cnt_r[AW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ld_idx_w[AW-1:0];
    wr_rem  = bsize_w[SIZE_BITS-1:0];
    wr_cnt  = '0;
    if (accept && (in_data.mode == MODE_LOAD) && ld_ok) begin
      wr_en = 1'b1;
    end else if ((state_r == ST_FIN) && (item_r.mode == MODE_ALLOC) && found) begin
      wr_en   = 1'b1;
      wr_addr = pick_idx;
      wr_rem  = new_rem;
      wr_cnt  = (pick_cnt == COUNT_MAX) ? pick_cnt : pick_cnt + COUNT_W'(1);
    end
  end

  always_comb begin
    ctl.clear   = accept;
    ctl.alloc   = (item_r.mode == MODE_ALLOC);
    ctl.report  = (item_r.mode == MODE_REPORT);
    ctl.policy  = policy_r;
    ctl.eval    = s1_vld_r;
    ctl.slot_ok = slot_valid_r[s1_idx_r];
  end

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    drain_nxt      = drain_r;
    s1_vld_nxt     = 1'b0;
    slot_valid_nxt = slot_valid_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.mode)
            MODE_CLEAR: begin
              slot_valid_nxt = '0;
              out_valid_nxt  = 1'b1;
              out_data_nxt   = '0;
            end
            MODE_LOAD: begin
              if (ld_ok) begin
                slot_valid_nxt[ld_idx_w[AW-1:0]] = 1'b1;
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = '0;
            end
            default: begin
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        s1_vld_nxt   = 1'b1;
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == CW'(NUM_BLOCKS - 1)) begin
          drain_nxt = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (item_r.mode == MODE_ALLOC) begin
          if (found) begin
            out_data_nxt.granted       = 1'b1;
            out_data_nxt.chosen_block  = pick_idx_w[IDX_W-1:0];
            out_data_nxt.left_in_block = left_w[FSIZE_W-1:0];
          end
        end else begin
          out_data_nxt.internal_frag = intf;
          out_data_nxt.external_frag = extf;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      scan_cnt_r   <= '0;
      drain_r      <= 1'b0;
      s1_vld_r     <= 1'b0;
      slot_valid_r <= '0;
      policy_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
      drain_r      <= drain_nxt;
      s1_vld_r     <= s1_vld_nxt;
      slot_valid_r <= slot_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        policy_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    s1_idx_r   <= rd_addr;
    out_data_r <= out_data_nxt;
  end

  fba_table #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS),
    .AW         (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rem  (wr_rem),
    .wr_cnt  (wr_cnt),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rem  (rd_rem),
    .rd_cnt  (rd_cnt)
  );

  fba_scan #(
    .SIZE_BITS (SIZE_BITS),
    .AW        (AW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .rd_idx   (s1_idx_r),
    .rd_rem   (rd_rem),
    .rd_cnt   (rd_cnt),
    .req      (req_m),
    .found    (found),
    .pick_idx (pick_idx),
    .pick_rem (pick_rem),
    .pick_cnt (pick_cnt),
    .intf     (intf),
    .extf     (extf)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while the sequencer is busy");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && ((in_data.mode == MODE_ALLOC) || (in_data.mode == MODE_REPORT)))
      |=> (state_r == ST_SCAN))
    else $error("allocate or report did not start a table scan");

  a_grant_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.granted) |-> (item_r.mode == MODE_ALLOC))
    else $error("grant reported for an item that is not an allocate");

  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> ((state_r == ST_SCAN) || (state_r == ST_DRAIN)))
    else $error("table read data outside a scan");

endmodule

`default_nettype wire
